// File: src/iee_pkg.sv
`default_nettype none

package iee_pkg;

  localparam int SPINS      = 8;
  localparam int FIELD_BITS = 8;

  localparam int STATE_W   = 8;
  localparam int ENERGY_W  = 12;
  localparam int EDGE_BITS = 28;
  localparam int FIELD_REG_W = 64;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 1;

  localparam int EDGE_USED  = SPINS * (SPINS - 1) / 2;
  localparam int EDGE_CNT_W = $clog2(EDGE_USED + 1);
  localparam int FTERM_W    = FIELD_BITS + 1;
  localparam int PAIR_W     = FTERM_W + 1;
  localparam int NPAIRS     = (SPINS + 1) / 2;

  // edge unit is 16 in Q4.4, agreement counted twice: 32*agree - 16*present
  localparam int EDGE_SHIFT = 4;

  localparam logic [CFG_IDX_W-1:0] REG_EDGE_MASK     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WEIGHTS = 1'b1;

  localparam int ENERGY_LIMIT = 1472;

  typedef logic        [STATE_W-1:0]  state_t;
  typedef logic signed [ENERGY_W-1:0] energy_t;
  typedef logic signed [FTERM_W-1:0]  fterm_t;
  typedef logic signed [PAIR_W-1:0]   fpair_t;
  typedef logic        [EDGE_CNT_W-1:0] ecnt_t;

endpackage

`default_nettype wire

// File: src/iee_in_if.sv
`default_nettype none

interface iee_in_if;
  import iee_pkg::*;

  logic   valid;
  logic   ready;
  state_t state_index;

  modport source (output valid, output state_index, input ready);
  modport sink   (input valid, input state_index, output ready);
endinterface

`default_nettype wire

// File: src/iee_out_if.sv
`default_nettype none

interface iee_out_if;
  import iee_pkg::*;

  logic    valid;
  logic    ready;
  energy_t energy;

  modport source (output valid, output energy, input ready);
  modport sink   (input valid, input energy, output ready);
endinterface

`default_nettype wire

// File: src/ising_energy_evaluator_top.sv
// Ising energy evaluator.
// in_ch carries one beat per basis state (state_index, bit j = spin j is +1).
// out_ch returns one beat per state: energy, signed Q8.4, 12 bits.
// Configuration: cfg_we with cfg_index 0 writes edge_mask (low 28 bits kept),
// index 1 writes field_weights. Write only while no beat is in flight.
// Pipeline: an input beat passes through the field pair sums and edge
// agreement, then the total field sum and agreement count, then the output
// register combining both.
// Throughput: one beat per cycle while out_ch.ready is high; each stage loads
// whenever it is empty or the stage after it moves, so bubbles close up.
// Stall: when out_ch.ready is low the output register holds its beat; the
// earlier stages keep filling until full, then in_ch.ready drops. Nothing is
// lost or repeated.
// Reset (rst_n low, synchronous): pipeline emptied, config registers and edge count cleared.
`default_nettype none

module ising_energy_evaluator_top (
  input  wire                            clk,
  input  wire                            rst_n,
  iee_in_if.sink                         in_ch,
  iee_out_if.source                      out_ch,
  input  wire                            cfg_we,
  input  wire [iee_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [iee_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import iee_pkg::*;

  logic [EDGE_BITS-1:0]   edge_mask_r;
  logic [FIELD_REG_W-1:0] field_weights_r;
  ecnt_t                  edge_cnt_r;
  ecnt_t                  edge_cnt_nxt;

  logic                   s1_v_r, s2_v_r, s3_v_r;
  fpair_t                 s1_fpair_r [NPAIRS];
  fpair_t                 s1_fpair_nxt [NPAIRS];
  logic [EDGE_USED-1:0]   s1_agree_r, s1_agree_nxt;
  energy_t                s2_fsum_r, s2_fsum_nxt;
  ecnt_t                  s2_acnt_r, s2_acnt_nxt;
  energy_t                s3_energy_r, s3_energy_nxt;

  logic                   rdy1, rdy2, rdy3;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_mask_r     <= '0;
      field_weights_r <= '0;
      edge_cnt_r      <= '0;
    end else begin
      edge_cnt_r <= edge_cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_EDGE_MASK:     edge_mask_r     <= cfg_wdata[EDGE_BITS-1:0];
          REG_FIELD_WEIGHTS: field_weights_r <= cfg_wdata[FIELD_REG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    edge_cnt_nxt = '0;
    for (int i = 0; i < EDGE_USED; i++) begin
      edge_cnt_nxt = edge_cnt_nxt + ecnt_t'(edge_mask_r[i]);
    end
  end

  // handshake chain
  assign rdy3        = !s3_v_r || out_ch.ready;
  assign rdy2        = !s2_v_r || rdy3;
  assign rdy1        = !s1_v_r || rdy2;
  assign in_ch.ready = rdy1;

  // stage 1: signed field terms summed in pairs, edge agreement bits
  always_comb begin
    fterm_t                  term [SPINS];
    logic signed [FIELD_BITS-1:0] f;
    for (int j = 0; j < SPINS; j++) begin
      f       = field_weights_r[8*j +: FIELD_BITS];
      term[j] = in_ch.state_index[j] ? -fterm_t'(f) : fterm_t'(f);
    end
    for (int p = 0; p < NPAIRS; p++) begin
      if (2*p + 1 < SPINS) begin
        s1_fpair_nxt[p] = fpair_t'(term[2*p]) + fpair_t'(term[2*p+1]);
      end else begin
        s1_fpair_nxt[p] = fpair_t'(term[2*p]);
      end
    end
    s1_agree_nxt = '0;
    for (int j = 1; j < SPINS; j++) begin
      for (int k = 0; k < j; k++) begin
        s1_agree_nxt[j*(j-1)/2 + k] = edge_mask_r[j*(j-1)/2 + k]
            & ~(in_ch.state_index[j] ^ in_ch.state_index[k]);
      end
    end
  end

  // stage 2: field total, agreement count
  always_comb begin
    s2_fsum_nxt = '0;
    for (int p = 0; p < NPAIRS; p++) begin
      s2_fsum_nxt = s2_fsum_nxt + energy_t'(s1_fpair_r[p]);
    end
    s2_acnt_nxt = '0;
    for (int i = 0; i < EDGE_USED; i++) begin
      s2_acnt_nxt = s2_acnt_nxt + ecnt_t'(s1_agree_r[i]);
    end
  end

  // stage 3: energy = fields + 16*(agree - disagree)
  always_comb begin
    energy_t agree_t, present_t;
    agree_t       = energy_t'(s2_acnt_r) <<< (EDGE_SHIFT + 1);
    present_t     = energy_t'(edge_cnt_r) <<< EDGE_SHIFT;
    s3_energy_nxt = s2_fsum_r + agree_t - present_t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_ch.valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_fpair_r <= s1_fpair_nxt;
      s1_agree_r <= s1_agree_nxt;
    end
    if (rdy2) begin
      s2_fsum_r <= s2_fsum_nxt;
      s2_acnt_r <= s2_acnt_nxt;
    end
    if (rdy3) begin
      s3_energy_r <= s3_energy_nxt;
    end
  end

  assign out_ch.valid  = s3_v_r;
  assign out_ch.energy = s3_energy_r;

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s1_v_r)
    else $error("accepted beat missing from stage 1");

  a_s2_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && rdy3) |=> s3_v_r)
    else $error("stage 2 beat lost on advance");

  a_agree_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (s2_acnt_r <= edge_cnt_r))
    else $error("agreement count exceeds edge count");

  a_energy_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> (s3_energy_r >= -energy_t'(ENERGY_LIMIT)
             && s3_energy_r <= energy_t'(ENERGY_LIMIT)))
    else $error("energy out of range");

endmodule

`default_nettype wire
